/* design/sfdx_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the serial frame deframer.
// No dependencies; every other design file imports this package.
package sfdx_pkg;

  localparam int unsigned OVERHEAD_BYTES = 6;

  // Register reset values
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd275;
  localparam logic [7:0]  START_BYTE_RST  = 8'd27;
  localparam logic [7:0]  TOKEN_BYTE_RST  = 8'd14;
  localparam logic [7:0]  PEER_CODE_RST   = 8'd176;
  localparam logic [7:0]  SEQ_RST         = 8'd1;

  typedef enum logic [1:0] {
    CFG_MAX_PAYLOAD = 2'd0,
    CFG_START_BYTE  = 2'd1,
    CFG_TOKEN_BYTE  = 2'd2,
    CFG_PEER_CODE   = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_SEQ    = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_TOKEN  = 3'd4,
    PH_DATA   = 3'd5,
    PH_CSUM   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    RK_PAYLOAD  = 2'd0,
    RK_COMPLETE = 2'd1,
    RK_ERROR    = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_TIMEOUT    = 3'd1,
    ERR_TOO_LONG   = 3'd2,
    ERR_PEER_CKSUM = 3'd3,
    ERR_BAD_CKSUM  = 3'd4
  } error_code_t;

  typedef struct packed {
    logic [15:0] max_payload;
    logic [7:0]  start_byte;
    logic [7:0]  token_byte;
    logic [7:0]  peer_cksum_error_code;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [16:0] frame_total;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

endpackage

/* design/sfdx_cfg.sv */
`timescale 1ns / 1ps
// Configuration register file of the deframer: four write-only registers.
// Depends on sfdx_pkg for cfg_t and the register index codes.
module sfdx_cfg import sfdx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  cfg_index_t  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_payload           <= MAX_PAYLOAD_RST;
      cfg.start_byte            <= START_BYTE_RST;
      cfg.token_byte            <= TOKEN_BYTE_RST;
      cfg.peer_cksum_error_code <= PEER_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_PAYLOAD: cfg.max_payload           <= cfg_data;
        CFG_START_BYTE:  cfg.start_byte            <= cfg_data[7:0];
        CFG_TOKEN_BYTE:  cfg.token_byte            <= cfg_data[7:0];
        CFG_PEER_CODE:   cfg.peer_cksum_error_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

/* design/sfdx_parser.sv */
`timescale 1ns / 1ps
// Frame parser: phase state machine, sequence/length/count/checksum state,
// and the one-beat result decode. Depends on sfdx_pkg.
module sfdx_parser import sfdx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    fire,
  input  item_t   item,
  output logic    has_result,
  output result_t res
);

  phase_t      phase, phase_next;
  logic [7:0]  expected_seq, expected_seq_next;
  logic [15:0] frame_len, frame_len_next;
  logic [15:0] received_count, received_count_next;
  logic [7:0]  running_xor, running_xor_next;

  logic [7:0]  xor_acc;
  logic [15:0] count_inc;
  logic        is_start, seq_ok, token_ok, over_limit, peer_err, data_done, cksum_bad;

  assign xor_acc    = running_xor ^ item.rx_byte;
  assign count_inc  = received_count + 16'd1;
  assign is_start   = (item.rx_byte == cfg.start_byte);
  assign seq_ok     = (item.rx_byte == expected_seq);
  assign token_ok   = (item.rx_byte == cfg.token_byte);
  assign over_limit = (received_count >= cfg.max_payload);
  assign peer_err   = (received_count == 16'd0) &&
                      (item.rx_byte == cfg.peer_cksum_error_code);
  assign data_done  = (count_inc == frame_len);
  assign cksum_bad  = (xor_acc != 8'd0);

  // Next phase
  always_comb begin
    phase_next = phase;
    if (item.kind) begin
      phase_next = PH_HUNT;
    end else begin
      unique case (phase)
        PH_HUNT:   phase_next = is_start ? PH_SEQ : PH_HUNT;
        PH_SEQ:    phase_next = seq_ok ? PH_LEN_HI : PH_HUNT;
        PH_LEN_HI: phase_next = PH_LEN_LO;
        PH_LEN_LO: phase_next = PH_TOKEN;
        PH_TOKEN:  phase_next = token_ok ? PH_DATA : PH_HUNT;
        PH_DATA: begin
          if (over_limit || peer_err) phase_next = PH_HUNT;
          else if (data_done)         phase_next = PH_CSUM;
          else                        phase_next = PH_DATA;
        end
        PH_CSUM:   phase_next = PH_HUNT;
        default:   phase_next = PH_HUNT;
      endcase
    end
  end

  // Datapath next values and result decode
  always_comb begin
    expected_seq_next   = expected_seq;
    frame_len_next      = frame_len;
    received_count_next = received_count;
    running_xor_next    = running_xor;
    has_result          = 1'b0;
    res                 = '0;
    if (item.kind) begin
      has_result     = 1'b1;
      res.result_kind = RK_ERROR;
      res.error_code  = ERR_TIMEOUT;
      res.last        = 1'b1;
    end else begin
      running_xor_next = xor_acc;
      unique case (phase)
        PH_HUNT: begin
          if (is_start) begin
            running_xor_next    = item.rx_byte;
            received_count_next = '0;
            frame_len_next      = '0;
          end
        end
        PH_SEQ: begin
          if (seq_ok) expected_seq_next = expected_seq + 8'd1;
        end
        PH_LEN_HI: frame_len_next = {item.rx_byte, 8'd0};
        PH_LEN_LO: frame_len_next = frame_len + {8'd0, item.rx_byte};
        PH_TOKEN: ;
        PH_DATA: begin
          has_result = 1'b1;
          if (over_limit) begin
            res.result_kind = RK_ERROR;
            res.error_code  = ERR_TOO_LONG;
            res.last        = 1'b1;
          end else if (peer_err) begin
            res.result_kind = RK_ERROR;
            res.error_code  = ERR_PEER_CKSUM;
            res.last        = 1'b1;
          end else begin
            received_count_next = count_inc;
            res.result_kind     = RK_PAYLOAD;
            res.payload_byte    = item.rx_byte;
            res.byte_index      = received_count;
          end
        end
        PH_CSUM: begin
          has_result = 1'b1;
          res.last   = 1'b1;
          if (cksum_bad) begin
            res.result_kind = RK_ERROR;
            res.error_code  = ERR_BAD_CKSUM;
          end else begin
            res.result_kind = RK_COMPLETE;
            res.frame_total = {1'b0, frame_len} + 17'(OVERHEAD_BYTES);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      expected_seq   <= SEQ_RST;
      frame_len      <= '0;
      received_count <= '0;
      running_xor    <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      expected_seq   <= expected_seq_next;
      frame_len      <= frame_len_next;
      received_count <= received_count_next;
      running_xor    <= running_xor_next;
    end
  end

  a_last_hunts: assert property (@(posedge clk) disable iff (rst)
    fire && has_result && res.last |=> phase == PH_HUNT)
    else $error("frame attempt ended but parser not hunting");

  a_timeout_reports: assert property (@(posedge clk) disable iff (rst)
    fire && item.kind |-> has_result && res.error_code == ERR_TIMEOUT)
    else $error("timeout event did not give a timeout error");

  a_payload_counts: assert property (@(posedge clk) disable iff (rst)
    fire && has_result && res.result_kind == RK_PAYLOAD
    |=> received_count == $past(received_count) + 16'd1)
    else $error("payload beat did not advance the byte count");

endmodule

/* design/sfdx_result_reg.sv */
`timescale 1ns / 1ps
// Result register: holds one result beat until the receiver takes it.
// Depends on sfdx_pkg for result_t.
module sfdx_result_reg import sfdx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  input  logic    result_stall,
  output logic    result_valid,
  output result_t result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res;
    end
  end

endmodule

/* design/serial_frame_deframer_xor_unit.sv */
`timescale 1ns / 1ps
// Serial frame deframer with XOR checksum: top level.
// Depends on sfdx_pkg, sfdx_cfg, sfdx_parser and sfdx_result_reg.
//
// Usage:
//   Item channel (item_valid / item_stall / item): one beat per link byte,
//   or a timeout/link-error event when item.kind is set. A beat is taken
//   at a clock edge with item_valid high and item_stall low.
//   Result channel (result_valid / result_stall / result): payload bytes
//   with their index, frame-complete beats with the total frame length,
//   and error beats. Bytes that give no result (header, hunting) produce
//   no beat.
//   Config port (cfg_we / cfg_index / cfg_data): single-cycle writes of
//   max_payload, start_byte, token_byte and the peer checksum error code.
//   Write only while the block is idle.
// Timing: one beat per cycle sustained while result_stall is low. A beat lands
//   in the input register, is parsed there by the combinational parser, and
//   its result is registered in the result register before it shows on the
//   result port.
// Reset: the parser hunts for the start byte, the expected sequence is 1,
//   registers return to their defaults, both channels drain empty.
// Stall: a held result keeps its beat; the input register keeps advancing
//   for beats that give no result and fills, then raises item_stall.
module serial_frame_deframer_xor_unit import sfdx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_we,
  input  cfg_index_t  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  logic    hold_valid;
  item_t   hold_item;
  logic    has_result;
  result_t res;
  logic    parse_fire;
  logic    item_take;

  sfdx_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Parse the held beat when its result (if any) has room to land:
  // the result register is empty or draining this cycle.
  assign parse_fire = hold_valid && (!has_result || !result_valid || !result_stall);
  assign item_stall = hold_valid && !parse_fire;
  assign item_take  = item_valid && !item_stall;

  // Input register: advance on a new beat, drop once parsed.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_take) begin
      hold_valid <= 1'b1;
    end else if (parse_fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      hold_item <= item;
    end
  end

  sfdx_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fire       (parse_fire),
    .item       (hold_item),
    .has_result (has_result),
    .res        (res)
  );

  sfdx_result_reg u_result (
    .clk          (clk),
    .rst          (rst),
    .load         (parse_fire && has_result),
    .res          (res),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

  // A parsed beat with a result must show on the result channel next cycle.
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    parse_fire && has_result |=> result_valid && result == $past(res))
    else $error("parsed result beat did not reach the result register");

  // Backpressure only while a beat waits in the input register.
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> hold_valid && result_valid && result_stall)
    else $error("item_stall raised without a blocked result");

endmodule

/* tb/serial_frame_deframer_xor_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for serial_frame_deframer_xor_unit: a scoreboard class tracks
// the deframer state and queues due results. Tasks drive frames, noise and events.
// Depends on sfdx_pkg and the serial_frame_deframer_xor_unit RTL only.
import sfdx_pkg::*;

class deframer_scoreboard;
  cfg_t        regs;
  phase_t      parse_state;
  logic [7:0]  exp_seq;
  logic [15:0] frame_len;
  logic [15:0] rx_count;
  logic [7:0]  run_xor;
  result_t     frame_results_due[$];
  int          errors;

  function new();
    regs        = '{MAX_PAYLOAD_RST, START_BYTE_RST, TOKEN_BYTE_RST, PEER_CODE_RST};
    parse_state = PH_HUNT;
    exp_seq     = SEQ_RST;
    frame_len   = '0;
    rx_count    = '0;
    run_xor     = '0;
    errors      = 0;
  endfunction

  function void write_reg(cfg_index_t idx, logic [15:0] data);
    case (idx)
      CFG_MAX_PAYLOAD: regs.max_payload           = data;
      CFG_START_BYTE:  regs.start_byte            = data[7:0];
      CFG_TOKEN_BYTE:  regs.token_byte            = data[7:0];
      CFG_PEER_CODE:   regs.peer_cksum_error_code = data[7:0];
      default: ;
    endcase
  endfunction

  function result_t abort_frame(error_code_t code);
    result_t r;
    r            = '0;
    r.result_kind = RK_ERROR;
    r.error_code  = code;
    r.last        = 1'b1;
    parse_state   = PH_HUNT;
    return r;
  endfunction

  // Advance the deframer by one accepted beat; queue the result it causes, if any.
  function void deframe_beat(item_t beat);
    result_t    r;
    bit         emits;
    logic [7:0] c;
    r     = '0;
    emits = 1'b0;
    c     = beat.rx_byte;
    if (beat.kind) begin
      r     = abort_frame(ERR_TIMEOUT);
      emits = 1'b1;
    end else begin
      run_xor = run_xor ^ c;
      case (parse_state)
        PH_HUNT: begin
          if (c == regs.start_byte) begin
            run_xor     = c;
            rx_count    = '0;
            frame_len   = '0;
            parse_state = PH_SEQ;
          end
        end
        PH_SEQ: begin
          if (c == exp_seq) begin
            exp_seq     = exp_seq + 8'd1;
            parse_state = PH_LEN_HI;
          end else begin
            parse_state = PH_HUNT;
          end
        end
        PH_LEN_HI: begin
          frame_len   = {c, 8'h00};
          parse_state = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_len   = frame_len + 16'(c);
          parse_state = PH_TOKEN;
        end
        PH_TOKEN: parse_state = (c == regs.token_byte) ? PH_DATA : PH_HUNT;
        PH_DATA: begin
          emits = 1'b1;
          if (rx_count >= regs.max_payload) begin
            r = abort_frame(ERR_TOO_LONG);
          end else if (rx_count == 16'd0 && c == regs.peer_cksum_error_code) begin
            r = abort_frame(ERR_PEER_CKSUM);
          end else begin
            r.result_kind  = RK_PAYLOAD;
            r.payload_byte = c;
            r.byte_index   = rx_count;
            rx_count       = rx_count + 16'd1;
            if (rx_count == frame_len) parse_state = PH_CSUM;
          end
        end
        PH_CSUM: begin
          emits = 1'b1;
          if (run_xor != 8'd0) begin
            r = abort_frame(ERR_BAD_CKSUM);
          end else begin
            r.result_kind = RK_COMPLETE;
            r.frame_total = 17'(frame_len) + 17'(OVERHEAD_BYTES);
            r.last        = 1'b1;
            parse_state   = PH_HUNT;
          end
        end
        default: parse_state = PH_HUNT;
      endcase
    end
    if (emits) frame_results_due.push_back(r);
  endfunction

  function void compare_field(string name, logic [16:0] want, logic [16:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (frame_results_due.size() == 0) begin
      errors++;
      $display("%0t: result beat with nothing due, actual %h", $time, got);
    end else begin
      want = frame_results_due.pop_front();
      compare_field("result_kind", 17'(want.result_kind), 17'(got.result_kind));
      compare_field("payload_byte", 17'(want.payload_byte), 17'(got.payload_byte));
      compare_field("byte_index", 17'(want.byte_index), 17'(got.byte_index));
      compare_field("frame_total", want.frame_total, got.frame_total);
      compare_field("error_code", 17'(want.error_code), 17'(got.error_code));
      compare_field("last", 17'(want.last), 17'(got.last));
    end
  endfunction
endclass

module serial_frame_deframer_xor_unit_test;

  // Slowest legal run is roughly 2000 beats, each with a long gap and a long stall;
  // this limit leaves a wide margin over that.
  localparam int CYCLE_LIMIT = 1000000;
  // Cut length that sends a whole frame.
  localparam int WHOLE = 1 << 20;
  // Beats per random phase.
  localparam int PHASE_BEATS = 240;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        cfg_we;
  cfg_index_t  cfg_index;
  logic [15:0] cfg_data;

  deframer_scoreboard sb = new();

  // Set during calm phases: no gaps on the input, no stalls on the output.
  bit steady = 1'b0;
  int beats_sent = 0;

  serial_frame_deframer_xor_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle length for either side: mostly none, often short, rarely long.
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one beat after a random gap; hold it until the block takes it, then
  // feed it to the scoreboard. Stall is sampled at the edge, before any update.
  task automatic push_beat(item_t beat);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= beat;
    do @(posedge clk); while (item_stall);
    sb.deframe_beat(beat);
  endtask

  task automatic push_byte(logic [7:0] b);
    push_beat(item_t'{kind: 1'b0, rx_byte: b});
    beats_sent++;
  endtask

  // Timeout or link error; the byte lane carries junk that must be ignored.
  task automatic push_event();
    push_beat(item_t'{kind: 1'b1, rx_byte: 8'($urandom)});
    beats_sent++;
  endtask

  // Build a frame with the given header fields and random payload, append the
  // XOR checksum (optionally corrupted), and send its first 'cut' bytes.
  task automatic send_frame(logic [7:0] seq, logic [15:0] len_field, logic [7:0] tok,
                            int n_payload, bit peer_first, logic [7:0] flip, int cut);
    logic [7:0] frame[$];
    logic [7:0] sum;
    frame.push_back(sb.regs.start_byte);
    frame.push_back(seq);
    frame.push_back(len_field[15:8]);
    frame.push_back(len_field[7:0]);
    frame.push_back(tok);
    for (int i = 0; i < n_payload; i++) begin
      if (i == 0 && peer_first) frame.push_back(sb.regs.peer_cksum_error_code);
      else frame.push_back(8'($urandom));
    end
    sum = 8'h00;
    foreach (frame[i]) sum = sum ^ frame[i];
    frame.push_back(sum ^ flip);
    for (int i = 0; i < frame.size() && i < cut; i++) push_byte(frame[i]);
  endtask

  // Drop valid, wait for every due result, then give the pipeline time to
  // finish any beat that produces nothing before touching the registers.
  task automatic settle();
    item_valid <= 1'b0;
    while (sb.frame_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all four registers on back-to-back cycles; byte registers get junk
  // in the upper half of the data bus, which the block must drop.
  task automatic program_regs(logic [15:0] max_v, logic [7:0] start_v, logic [7:0] tok_v,
                              logic [7:0] peer_v);
    cfg_index_t  order[4];
    logic [15:0] data[4];
    order = '{CFG_MAX_PAYLOAD, CFG_START_BYTE, CFG_TOKEN_BYTE, CFG_PEER_CODE};
    data  = '{max_v, {8'($urandom), start_v}, {8'($urandom), tok_v}, {8'($urandom), peer_v}};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= data[i];
      @(posedge clk);
      sb.write_reg(order[i], data[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed frames with random content; the rest are broken frames
  // of every flavor and stray noise.
  task automatic random_traffic(int quota);
    int          first;
    int          pick;
    int          mx;
    int          hi;
    int          n;
    logic [15:0] len_field;
    first = beats_sent;
    while (beats_sent - first < quota) begin
      // Force the parser back to hunting so the next frame lines up.
      if (sb.parse_state != PH_HUNT) push_event();
      mx = sb.regs.max_payload;
      hi = (mx == 0) ? 4 : ((mx < 12) ? mx : 12);
      if (mx > 12 && $urandom_range(0, 19) == 0) hi = (mx < 300) ? mx : 300;
      n    = $urandom_range(1, hi);
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        send_frame(sb.exp_seq, 16'(n), sb.regs.token_byte, n, 1'b0, 8'h00, WHOLE);
      end else if (pick < 68) begin
        // corrupted checksum
        send_frame(sb.exp_seq, 16'(n), sb.regs.token_byte, n, 1'b0,
                   8'($urandom_range(1, 255)), WHOLE);
      end else if (pick < 72) begin
        // peer reports a checksum error in the first payload byte
        send_frame(sb.exp_seq, 16'(n), sb.regs.token_byte, n, 1'b1, 8'h00, WHOLE);
      end else if (pick < 76) begin
        send_frame(sb.exp_seq ^ 8'($urandom_range(1, 255)), 16'(n), sb.regs.token_byte,
                   n, 1'b0, 8'h00, WHOLE);
      end else if (pick < 80) begin
        send_frame(sb.exp_seq, 16'(n), sb.regs.token_byte ^ 8'($urandom_range(1, 255)),
                   n, 1'b0, 8'h00, WHOLE);
      end else if (pick < 86) begin
        // timeout somewhere inside the frame
        send_frame(sb.exp_seq, 16'(n), sb.regs.token_byte, n, 1'b0, 8'h00,
                   $urandom_range(1, n + 5));
        push_event();
      end else if (pick < 92 && mx <= 64) begin
        // length past the limit, or zero: one byte over max_payload trips the limit
        len_field = ($urandom_range(0, 3) == 0) ? 16'h0000 :
                    16'($urandom_range(mx + 1, 65535));
        send_frame(sb.exp_seq, len_field, sb.regs.token_byte, mx + 1, 1'b0, 8'h00, mx + 6);
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      end
    end
  endtask

  task automatic run_phase(logic [15:0] max_v, logic [7:0] start_v, logic [7:0] tok_v,
                           logic [7:0] peer_v, bit calm);
    steady = calm;
    program_regs(max_v, start_v, tok_v, peer_v);
    random_traffic(PHASE_BEATS);
    settle();
  endtask

  // Output side: random stall runs; check every beat the block hands over.
  initial begin : result_side
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left   = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) sb.check_result(result);
      if (steady) stall_left = 0;
      if (stall_left == 0 && run_left == 0) begin
        stall_left = idle_len();
        run_left   = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
        if (run_left > 0) run_left--;
      end
    end
  end

  // Hang guard.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_MAX_PAYLOAD;
    cfg_data   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass at reset register values.
    push_event();                                         // timeout while hunting
    push_beat(item_t'{kind: 1'b0, rx_byte: 8'h00});       // not a start byte: ignored
    push_beat(item_t'{kind: 1'b0, rx_byte: 8'hFF});
    send_frame(sb.exp_seq, 16'd2, sb.regs.token_byte, 2, 1'b0, 8'h00, WHOLE);
    // Sequence mismatch: back to hunting, expected sequence unchanged.
    send_frame(sb.exp_seq ^ 8'h04, 16'd1, sb.regs.token_byte, 1, 1'b0, 8'h00, 2);
    // Wrong token after a good header: sequence still advances.
    send_frame(sb.exp_seq, 16'd1, sb.regs.token_byte ^ 8'h01, 1, 1'b0, 8'h00, 5);
    // Peer checksum report in the first payload byte.
    send_frame(sb.exp_seq, 16'd1, sb.regs.token_byte, 1, 1'b1, 8'h00, 6);
    settle();

    // Register extremes first, then mixed settings; calm phases interleaved.
    run_phase(16'hFFFF, 8'hFF, 8'h00, 8'hFF, 1'b0);
    run_phase(16'h0000, 8'h00, 8'hFF, 8'h00, 1'b1);
    run_phase(16'd3, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    run_phase(MAX_PAYLOAD_RST, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    run_phase(16'($urandom_range(1, 40)), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    run_phase(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    run_phase(16'($urandom_range(0, 12)), 8'h55, 8'hAA, 8'($urandom), 1'b0);
    run_phase(16'd1, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);

    if (sb.errors == 0 && sb.frame_results_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
